// ===== rtl/cai_pkg.sv =====
// Shared types, constants and code tables of the coin acceptor interface.
// No dependencies; every other file imports this package.
package cai_pkg;

	localparam int CoinLines = 6;
	localparam int NumLines = (CoinLines < 6) ? CoinLines : 6;
	localparam logic [7:0] LineExist = 8'((9'd1 << NumLines) - 9'd1);

	localparam logic [31:0] CpsReset = 32'd16000000;
	localparam logic [31:0] Div10Mul = 32'hCCCCCCCD;
	localparam int Div10Shift = 35;

	localparam logic [3:0] REG_COMM_STYLE = 4'd0;
	localparam logic [3:0] REG_COMM_INVERT = 4'd1;
	localparam logic [3:0] REG_PULSE_CYCLES = 4'd2;
	localparam logic [3:0] REG_CYCLES_PER_SECOND = 4'd3;
	localparam logic [3:0] REG_LINE_ENABLE = 4'd4;
	localparam logic [3:0] REG_INHIBIT_INVERT = 4'd5;
	localparam logic [3:0] REG_DRIVE_MAP = 4'd6;
	localparam logic [3:0] REG_DENOM_MAP = 4'd7;

	localparam logic [7:0] SelectBit = 8'h04;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_INSERT,
		OP_WRITE,
		OP_READ
	} op_t;

	typedef enum logic [1:0] {
		STYLE_ONEHOT,
		STYLE_BINARY,
		STYLE_BCD,
		STYLE_CHANNEL
	} style_t;

	typedef struct packed {
		style_t      comm_style;
		logic        comm_invert;
		logic [31:0] pulse_cycles;
		logic [31:0] min_pulse;
		logic [31:0] lock_load;
		logic [5:0]  line_enable;
		logic [5:0]  inhibit_invert;
		logic [17:0] drive_map;
		logic [47:0] denom_map;
	} cfg_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] elapsed_cycles;
		logic [2:0]  coin_line;
		logic [7:0]  denomination;
		logic [7:0]  inhibit_bits;
	} item_t;

	typedef struct packed {
		logic       accepted;
		logic [7:0] presented_byte;
		logic [5:0] lockout_mask;
	} res_t;

	function automatic logic [7:0] binary_code(logic [7:0] value);
		logic [7:0] code;
		unique case (value)
			8'd1, 8'd7:  code = 8'h10;
			8'd2, 8'd8:  code = 8'h38;
			8'd3, 8'd9:  code = 8'hD0;
			8'd4, 8'd10: code = 8'hB0;
			8'd5, 8'd11: code = 8'h58;
			8'd6, 8'd12: code = 8'hF8;
			default:     code = 8'h00;
		endcase
		return code;
	endfunction

	function automatic logic [7:0] legacy_code(logic [2:0] line);
		logic [7:0] code;
		unique case (line)
			3'd0:    code = 8'h08;
			3'd1:    code = 8'h0C;
			3'd2:    code = 8'h0B;
			3'd3:    code = 8'h0E;
			3'd4:    code = 8'h0D;
			3'd5:    code = 8'h1A;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

	function automatic logic [7:0] bcd_code(logic [7:0] value);
		logic [7:0] code;
		unique case (value)
			8'd0:         code = 8'h02;
			8'd1, 8'd7:   code = 8'h05;
			8'd2, 8'd8:   code = 8'h0A;
			8'd3, 8'd9:   code = 8'h14;
			8'd4, 8'd10:  code = 8'h32;
			8'd5:         code = 8'h3A;
			8'd11:        code = 8'h64;
			8'd6, 8'd12:  code = 8'hC8;
			default:      code = value;
		endcase
		return code;
	endfunction

endpackage

// ===== rtl/cai_cfg_regs.sv =====
// Configuration registers of the coin acceptor interface, with the derived
// minimum pulse and lockout lengths. Depends on cai_pkg.
module cai_cfg_regs import cai_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_index,
	input  logic [47:0] cfg_wdata,
	output cfg_t        cfg
);

	cfg_t        cfg_q;
	logic [63:0] prod;
	logic [31:0] div10;

	assign prod  = 64'(cfg_wdata[31:0]) * 64'(Div10Mul);
	assign div10 = 32'(prod[63:Div10Shift]);
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.comm_style     <= STYLE_ONEHOT;
			cfg_q.comm_invert    <= 1'b0;
			cfg_q.pulse_cycles   <= 32'd0;
			cfg_q.min_pulse      <= CpsReset / 10;
			cfg_q.lock_load      <= CpsReset >> 1;
			cfg_q.line_enable    <= 6'h3F;
			cfg_q.inhibit_invert <= 6'h00;
			cfg_q.drive_map      <= 18'd181896;
			cfg_q.denom_map      <= 48'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COMM_STYLE:   cfg_q.comm_style   <= style_t'(cfg_wdata[1:0]);
				REG_COMM_INVERT:  cfg_q.comm_invert  <= cfg_wdata[0];
				REG_PULSE_CYCLES: cfg_q.pulse_cycles <= cfg_wdata[31:0];
				REG_CYCLES_PER_SECOND: begin
					cfg_q.min_pulse <= (div10 == 32'd0) ? 32'd1 : div10;
					cfg_q.lock_load <= {1'b0, cfg_wdata[31:1]};
				end
				REG_LINE_ENABLE:    cfg_q.line_enable    <= cfg_wdata[5:0];
				REG_INHIBIT_INVERT: cfg_q.inhibit_invert <= cfg_wdata[5:0];
				REG_DRIVE_MAP:      cfg_q.drive_map      <= cfg_wdata[17:0];
				REG_DENOM_MAP:      cfg_q.denom_map      <= cfg_wdata;
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/cai_core.sv =====
// Coin acceptor state (pulse, lockout, held code, inhibit byte) and the
// single-pass logic that executes one word and forms its result.
// Depends on cai_pkg.
module cai_core import cai_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  item_t item,
	input  logic  step,
	output res_t  res
);

	function automatic logic [7:0] permit_mask(logic [7:0] inh, logic [23:0] drv,
			logic [7:0] inv);
		logic [7:0] m;
		for (int i = 0; i < 8; i++) begin
			m[i] = inh[drv[3*i +: 3]] ^ inv[i];
		end
		return m;
	endfunction

	logic [31:0] pulse_q, lock_q, pulse_d, lock_d, lock_base, eff_pulse;
	logic [7:0]  raw_q, inh_q, raw_d, inh_d;
	logic [23:0] drv_ext;
	logic [63:0] denom_ext;
	logic [7:0]  enable8, permit_now, permit_new, value, code, bin, pres;
	logic [2:0]  drive;
	logic        busy_now, busy_new, expire, insert_ok;

	assign drv_ext   = {6'd0, cfg.drive_map};
	assign denom_ext = {16'd0, cfg.denom_map};
	assign enable8   = {2'b00, cfg.line_enable} & LineExist;
	assign eff_pulse = (cfg.pulse_cycles < cfg.min_pulse) ? cfg.min_pulse : cfg.pulse_cycles;
	assign busy_now  = (raw_q != 8'd0) || (pulse_q != 32'd0) || (lock_q != 32'd0);
	assign permit_now = permit_mask(inh_q, drv_ext, {2'b00, cfg.inhibit_invert});
	assign drive     = drv_ext[3*item.coin_line +: 3];
	assign value     = (item.denomination != 8'd0) ? item.denomination
		: denom_ext[{item.coin_line, 3'b000} +: 8];
	assign bin       = binary_code(value);

	always_comb begin
		unique case (cfg.comm_style)
			STYLE_ONEHOT:  code = 8'(9'd1 << drive);
			STYLE_BINARY:  code = (bin != 8'd0) ? bin : legacy_code(item.coin_line);
			STYLE_BCD:     code = bcd_code(value);
			STYLE_CHANNEL: code = 8'(item.coin_line) + 8'd1;
			default:       code = 8'd0;
		endcase
	end

	assign insert_ok = enable8[item.coin_line] && !busy_now && permit_now[item.coin_line]
		&& (code != 8'd0);
	assign expire    = (pulse_q != 32'd0) && (item.elapsed_cycles >= pulse_q);
	assign lock_base = expire ? cfg.lock_load : lock_q;

	always_comb begin
		pulse_d = pulse_q;
		lock_d  = lock_q;
		raw_d   = raw_q;
		inh_d   = inh_q;
		unique case (item.op)
			OP_TICK: begin
				if (expire) begin
					pulse_d = 32'd0;
					raw_d   = 8'd0;
				end else if (pulse_q != 32'd0) begin
					pulse_d = pulse_q - item.elapsed_cycles;
				end
				lock_d = (item.elapsed_cycles >= lock_base) ? 32'd0
					: lock_base - item.elapsed_cycles;
			end
			OP_INSERT: begin
				if (insert_ok) begin
					raw_d   = code;
					pulse_d = eff_pulse;
				end
			end
			OP_WRITE: inh_d = item.inhibit_bits;
			OP_READ: ;
			default: ;
		endcase
	end

	assign busy_new   = (raw_d != 8'd0) || (pulse_d != 32'd0) || (lock_d != 32'd0);
	assign permit_new = permit_mask(inh_d, drv_ext, {2'b00, cfg.inhibit_invert});
	assign pres       = raw_d | ((cfg.comm_style == STYLE_BINARY) ? SelectBit : 8'd0);

	always_comb begin
		res.accepted       = (item.op == OP_INSERT) && insert_ok;
		res.presented_byte = cfg.comm_invert ? ~pres : pres;
		res.lockout_mask   = 6'((busy_new ? 8'hFF : ~(enable8 & permit_new)) & LineExist);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q <= 32'd0;
			lock_q  <= 32'd0;
			raw_q   <= 8'd0;
			inh_q   <= 8'hFF;
		end else if (step) begin
			pulse_q <= pulse_d;
			lock_q  <= lock_d;
			raw_q   <= raw_d;
			inh_q   <= inh_d;
		end
	end

endmodule

// ===== rtl/coin_acceptor_interface.sv =====
// Coin acceptor interface top level: input register, execution core, result register.
// Throughput: one word per cycle unless out_ready stalls the output; the core state updates
// as each word leaves the input register, whose result is captured in the result register.
// Reset (arst_n low, asynchronous) clears both pipeline stages and the coin state;
// configuration returns to its defaults. Depends on cai_pkg, cai_cfg_regs and cai_core.
module coin_acceptor_interface import cai_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_index,
	input  logic [47:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [31:0] elapsed_cycles,
	input  logic [2:0]  coin_line,
	input  logic [7:0]  denomination,
	input  logic [7:0]  inhibit_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        accepted,
	output logic [7:0]  presented_byte,
	output logic [5:0]  lockout_mask
);

	cfg_t  cfg;
	item_t item_s1;
	res_t  res, res_s2;
	logic  valid_s1, valid_s2, advance, step;

	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	cai_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	cai_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.step   (step),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.op             <= op_t'(op);
			item_s1.elapsed_cycles <= elapsed_cycles;
			item_s1.coin_line      <= coin_line;
			item_s1.denomination   <= denomination;
			item_s1.inhibit_bits   <= inhibit_bits;
		end
		if (step) begin
			res_s2 <= res;
		end
	end

	assign out_valid      = valid_s2;
	assign accepted       = res_s2.accepted;
	assign presented_byte = res_s2.presented_byte;
	assign lockout_mask   = res_s2.lockout_mask;

endmodule

// ===== rtl/cai_checker.sv =====
// Port-level checks of the coin acceptor interface, bound to the top level.
// Depends on cai_pkg and coin_acceptor_interface.
module cai_checker import cai_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        accepted,
	input logic [7:0]  presented_byte,
	input logic [5:0]  lockout_mask
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("Result valid during reset.");

	a_stall_only: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("Input stalled while the output side could advance.");

	a_accept_locks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && accepted) |-> (lockout_mask == LineExist[5:0]))
		else $error("Accepted coin did not lock all lines.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(accepted)
			&& $stable(presented_byte) && $stable(lockout_mask)))
		else $error("Stalled result changed.");

endmodule

bind coin_acceptor_interface cai_checker u_cai_checker (.*);

// ===== tb/coin_acceptor_interface_checker.sv =====
// Checker for coin_acceptor_interface: watches the register port and both word channels,
// predicts every result from its own copy of the acceptor state and compares it.
// Depends on cai_pkg for the operation and style codes and the register indexes.
module coin_acceptor_interface_checker import cai_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_index,
	input  logic [47:0] cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  op,
	input  logic [31:0] elapsed_cycles,
	input  logic [2:0]  coin_line,
	input  logic [7:0]  denomination,
	input  logic [7:0]  inhibit_bits,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        accepted,
	input  logic [7:0]  presented_byte,
	input  logic [5:0]  lockout_mask,
	output int          words_in_flight,
	output int          mismatch_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_COUNT = 6;

	style_t      style_r;
	logic        invert_r;
	logic [31:0] pulse_r;
	logic [31:0] rate_r;
	logic [5:0]  enable_r;
	logic [5:0]  inh_invert_r;
	logic [17:0] drive_r;
	logic [47:0] denom_r;

	logic [31:0] pulse_left;
	logic [31:0] lock_left;
	logic [7:0]  held_code;
	logic [7:0]  inhibit_out;

	res_t expected_results[$];

	function automatic logic [2:0] drive_bit(input logic [2:0] line);
		return 3'((drive_r >> (3 * line)) & 18'd7);
	endfunction

	function automatic bit line_permits(input logic [2:0] line);
		bit permits;
		permits = inhibit_out[drive_bit(line)];
		if (inh_invert_r[line]) begin
			permits = !permits;
		end
		return permits;
	endfunction

	function automatic bit acceptor_busy();
		return held_code != 8'd0 || pulse_left != 32'd0 || lock_left != 32'd0;
	endfunction

	function automatic logic [7:0] binary_table(input logic [7:0] value);
		case (value)
			8'd1, 8'd7:  return 8'h10;
			8'd2, 8'd8:  return 8'h38;
			8'd3, 8'd9:  return 8'hD0;
			8'd4, 8'd10: return 8'hB0;
			8'd5, 8'd11: return 8'h58;
			8'd6, 8'd12: return 8'hF8;
			default:     return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] fallback_code(input logic [2:0] line);
		case (line)
			3'd0:    return 8'h08;
			3'd1:    return 8'h0C;
			3'd2:    return 8'h0B;
			3'd3:    return 8'h0E;
			3'd4:    return 8'h0D;
			3'd5:    return 8'h1A;
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] bcd_table(input logic [7:0] value);
		case (value)
			8'd0:        return 8'h02;
			8'd1, 8'd7:  return 8'h05;
			8'd2, 8'd8:  return 8'h0A;
			8'd3, 8'd9:  return 8'h14;
			8'd4, 8'd10: return 8'h32;
			8'd5:        return 8'h3A;
			8'd6, 8'd12: return 8'hC8;
			8'd11:       return 8'h64;
			default:     return value;
		endcase
	endfunction

	function automatic logic [7:0] coin_code(input logic [2:0] line, input logic [7:0] value);
		logic [7:0] code;
		case (style_r)
			STYLE_ONEHOT: code = 8'd1 << drive_bit(line);
			STYLE_BINARY: begin
				code = binary_table(value);
				if (code == 8'd0) begin
					code = fallback_code(line);
				end
			end
			STYLE_BCD:    code = bcd_table(value);
			default:      code = 8'({5'd0, line} + 8'd1);
		endcase
		return code;
	endfunction

	function automatic logic [31:0] pulse_length();
		logic [31:0] floor_len;
		floor_len = rate_r / 32'd10;
		if (floor_len == 32'd0) begin
			floor_len = 32'd1;
		end
		return (pulse_r < floor_len) ? floor_len : pulse_r;
	endfunction

	task automatic advance_acceptor(input op_t o, input logic [31:0] elapsed,
			input logic [2:0] line, input logic [7:0] denom, input logic [7:0] inh,
			output res_t r);
		logic [7:0] value;
		logic [7:0] code;
		logic [7:0] shown;
		bit         now_busy;
		r = '0;
		case (o)
			OP_TICK: begin
				if (pulse_left != 32'd0) begin
					if (elapsed >= pulse_left) begin
						pulse_left = 32'd0;
						held_code = 8'd0;
						lock_left = rate_r / 32'd2;
					end else begin
						pulse_left = pulse_left - elapsed;
					end
				end
				if (lock_left != 32'd0) begin
					lock_left = (elapsed >= lock_left) ? 32'd0 : lock_left - elapsed;
				end
			end
			OP_INSERT: begin
				if (line < LINE_COUNT && enable_r[line] && !acceptor_busy() &&
						line_permits(line)) begin
					value = (denom != 8'd0) ? denom : denom_r[8 * line +: 8];
					code = coin_code(line, value);
					if (code != 8'd0) begin
						held_code = code;
						pulse_left = pulse_length();
						r.accepted = 1'b1;
					end
				end
			end
			OP_WRITE: inhibit_out = inh;
			default: ;
		endcase
		shown = held_code;
		if (style_r == STYLE_BINARY) begin
			shown = shown | 8'h04;
		end
		if (invert_r) begin
			shown = ~shown;
		end
		r.presented_byte = shown;
		now_busy = acceptor_busy();
		for (int i = 0; i < LINE_COUNT; i++) begin
			if (now_busy || !enable_r[i] || !line_permits(3'(i))) begin
				r.lockout_mask[i] = 1'b1;
			end
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t predicted;
		if (!arst_n) begin
			style_r = STYLE_ONEHOT;
			invert_r = 1'b0;
			pulse_r = 32'd0;
			rate_r = 32'd16000000;
			enable_r = 6'h3F;
			inh_invert_r = 6'h00;
			drive_r = 18'd181896;
			denom_r = 48'd0;
			pulse_left = 32'd0;
			lock_left = 32'd0;
			held_code = 8'd0;
			inhibit_out = 8'hFF;
			expected_results.delete();
			mismatch_count = 0;
			words_in_flight <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result word with nothing expected",
						{17'd0, accepted, presented_byte, lockout_mask}, 32'd0);
				end else begin
					want = expected_results.pop_front();
					if (accepted !== want.accepted) begin
						report_mismatch("accepted", 32'(accepted), 32'(want.accepted));
					end
					if (presented_byte !== want.presented_byte) begin
						report_mismatch("presented_byte", 32'(presented_byte),
							32'(want.presented_byte));
					end
					if (lockout_mask !== want.lockout_mask) begin
						report_mismatch("lockout_mask", 32'(lockout_mask),
							32'(want.lockout_mask));
					end
				end
			end
			if (in_valid && in_ready) begin
				advance_acceptor(op_t'(op), elapsed_cycles, coin_line, denomination,
					inhibit_bits, predicted);
				expected_results.push_back(predicted);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_COMM_STYLE:        style_r = style_t'(cfg_wdata[1:0]);
					REG_COMM_INVERT:       invert_r = cfg_wdata[0];
					REG_PULSE_CYCLES:      pulse_r = cfg_wdata[31:0];
					REG_CYCLES_PER_SECOND: rate_r = cfg_wdata[31:0];
					REG_LINE_ENABLE:       enable_r = cfg_wdata[5:0];
					REG_INHIBIT_INVERT:    inh_invert_r = cfg_wdata[5:0];
					REG_DRIVE_MAP:         drive_r = cfg_wdata[17:0];
					REG_DENOM_MAP:         denom_r = cfg_wdata[47:0];
					default: ;
				endcase
			end
			words_in_flight <= expected_results.size();
		end
	end

endmodule

// ===== tb/coin_acceptor_interface_tb.sv =====
// Top of the coin_acceptor_interface testbench: clock, reset, register setup and word stimulus.
// Depends on cai_pkg, the block itself and coin_acceptor_interface_checker.
module coin_acceptor_interface_tb import cai_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [3:0]  cfg_index;
	logic [47:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [31:0] elapsed_cycles;
	logic [2:0]  coin_line;
	logic [7:0]  denomination;
	logic [7:0]  inhibit_bits;
	logic        out_valid;
	logic        out_ready;
	logic        accepted;
	logic [7:0]  presented_byte;
	logic [5:0]  lockout_mask;

	int          words_in_flight;
	int          mismatch_count;

	bit          no_idle;
	bit          hold_request;
	logic [31:0] rate_now;

	coin_acceptor_interface dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.elapsed_cycles(elapsed_cycles),
		.coin_line(coin_line),
		.denomination(denomination),
		.inhibit_bits(inhibit_bits),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.accepted(accepted),
		.presented_byte(presented_byte),
		.lockout_mask(lockout_mask)
	);

	coin_acceptor_interface_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.elapsed_cycles(elapsed_cycles),
		.coin_line(coin_line),
		.denomination(denomination),
		.inhibit_bits(inhibit_bits),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.accepted(accepted),
		.presented_byte(presented_byte),
		.lockout_mask(lockout_mask),
		.words_in_flight(words_in_flight),
		.mismatch_count(mismatch_count)
	);

	initial begin
		clk = 1'b0;
	end

	always #1 clk = ~clk;

	function automatic int pick_gap();
		int r;
		if (no_idle) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end else if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Result side: random back-pressure, plus one long hold while words keep coming.
	initial begin
		int gap_left;
		bit hold_done;
		gap_left = 0;
		hold_done = 1'b0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (60) @(posedge clk);
				out_ready <= 1'b1;
			end else if (gap_left > 0) begin
				out_ready <= 1'b0;
				gap_left--;
			end else begin
				out_ready <= 1'b1;
				gap_left = pick_gap();
			end
		end
	end

	task automatic send_word(input op_t o, input logic [31:0] e, input logic [2:0] l,
			input logic [7:0] d, input logic [7:0] ib);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		elapsed_cycles <= e;
		coin_line <= l;
		denomination <= d;
		inhibit_bits <= ib;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic settle_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (words_in_flight != 0);
	endtask

	// Bits above the register width carry junk, which the block must drop.
	task automatic write_reg(input logic [3:0] index, input logic [47:0] value, input int width);
		logic [47:0] junk;
		junk = 48'({$urandom(), $urandom()});
		if (width < 48) begin
			junk = junk << width;
		end else begin
			junk = '0;
		end
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= junk | value;
		if (index == REG_CYCLES_PER_SECOND) begin
			rate_now = value[31:0];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_word();
		int          r;
		logic [31:0] span;
		op_t         o;
		logic [31:0] e;
		logic [2:0]  l;
		logic [7:0]  d;
		logic [7:0]  ib;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			o = OP_TICK;
		end else if (r < 75) begin
			o = OP_INSERT;
		end else if (r < 85) begin
			o = OP_WRITE;
		end else begin
			o = OP_READ;
		end
		span = (rate_now > 32'd800) ? 32'd100 : rate_now / 32'd8 + 32'd3;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			e = 32'd0;
		end else if (r < 8) begin
			e = 32'hFFFFFFFF;
		end else if (r < 18) begin
			e = $urandom();
		end else begin
			e = $urandom_range(1, span);
		end
		l = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 5)) : 3'($urandom_range(6, 7));
		r = $urandom_range(0, 99);
		if (r < 30) begin
			d = 8'd0;
		end else if (r < 80) begin
			d = 8'($urandom_range(1, 14));
		end else begin
			d = 8'($urandom());
		end
		r = $urandom_range(0, 99);
		if (r < 50) begin
			ib = 8'hFF;
		end else if (r < 80) begin
			ib = 8'($urandom());
		end else begin
			ib = ~(8'd1 << $urandom_range(0, 7));
		end
		send_word(o, e, l, d, ib);
	endtask

	task automatic configure_phase(input int p);
		logic [31:0] pulse;
		logic [31:0] rate;
		logic [5:0]  enable;
		logic [5:0]  inh_inv;
		logic [17:0] drive;
		logic [47:0] denoms;
		case (p % 3)
			0:       pulse = 32'd0;
			1:       pulse = $urandom_range(1, 60);
			default: pulse = 32'hFFFFFFFF;
		endcase
		case (p)
			1:       rate = 32'd1;
			3:       rate = 32'hFFFFFFFF;
			6:       rate = 32'd0;
			default: rate = $urandom_range(10, 400);
		endcase
		case (p)
			0:       enable = 6'h3F;
			5:       enable = 6'h00;
			default: enable = 6'($urandom() | $urandom());
		endcase
		inh_inv = (p == 7) ? 6'h3F : 6'($urandom() & $urandom());
		case (p)
			2:       drive = 18'h3FFFF;
			4:       drive = 18'h00000;
			default: drive = 18'($urandom());
		endcase
		for (int k = 0; k < 6; k++) begin
			denoms[8 * k +: 8] = (p % 2 == 0) ? 8'($urandom_range(0, 14)) : 8'($urandom());
		end
		write_reg(REG_COMM_STYLE, 48'(p % 4), 2);
		write_reg(REG_COMM_INVERT, 48'((p / 4) % 2), 1);
		write_reg(REG_PULSE_CYCLES, 48'(pulse), 32);
		write_reg(REG_CYCLES_PER_SECOND, 48'(rate), 32);
		write_reg(REG_LINE_ENABLE, 48'(enable), 6);
		write_reg(REG_INHIBIT_INVERT, 48'(inh_inv), 6);
		write_reg(REG_DRIVE_MAP, 48'(drive), 18);
		write_reg(REG_DENOM_MAP, denoms, 48);
		write_reg(REG_DENOM_MAP + 4'd1 + 4'($urandom_range(0, 7)),
			48'({$urandom(), $urandom()}), 48);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		op = OP_READ;
		elapsed_cycles = '0;
		coin_line = '0;
		denomination = '0;
		inhibit_bits = '0;
		no_idle = 1'b0;
		hold_request = 1'b0;
		rate_now = 32'd16000000;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: missing lines, counter floor, inhibited line.
		send_word(OP_READ, 32'd0, 3'd0, 8'd0, 8'd0);
		send_word(OP_TICK, 32'hFFFFFFFF, 3'd0, 8'd0, 8'd0);
		send_word(OP_INSERT, 32'd0, 3'd7, 8'hFF, 8'd0);
		send_word(OP_INSERT, 32'd0, 3'd6, 8'd1, 8'd0);
		send_word(OP_WRITE, 32'd0, 3'd0, 8'd0, 8'h00);
		send_word(OP_INSERT, 32'd0, 3'd2, 8'd0, 8'd0);
		send_word(OP_READ, 32'd0, 3'd0, 8'd0, 8'd0);
		send_word(OP_WRITE, 32'd0, 3'd0, 8'd0, 8'hFF);

		// Binary style at a zero clock rate, with the legacy fallback and a disabled line.
		settle_idle();
		write_reg(REG_COMM_STYLE, 48'(STYLE_BINARY), 2);
		write_reg(REG_CYCLES_PER_SECOND, 48'd0, 32);
		write_reg(REG_LINE_ENABLE, 48'h3B, 6);
		write_reg(REG_DENOM_MAP, 48'h0000_1400_0000, 48);
		write_reg(4'd15, 48'hFFFF_FFFF_FFFF, 48);
		send_word(OP_INSERT, 32'd0, 3'd3, 8'd0, 8'd0);
		send_word(OP_TICK, 32'd0, 3'd0, 8'd0, 8'd0);
		send_word(OP_TICK, 32'd1, 3'd0, 8'd0, 8'd0);
		send_word(OP_INSERT, 32'd0, 3'd2, 8'd1, 8'd0);
		send_word(OP_INSERT, 32'd0, 3'd1, 8'd6, 8'd0);
		send_word(OP_TICK, 32'd5, 3'd0, 8'd0, 8'd0);

		// Inverted BCD style: out-of-table index, pulse expiry and lockout countdown.
		settle_idle();
		write_reg(REG_COMM_STYLE, 48'(STYLE_BCD), 2);
		write_reg(REG_COMM_INVERT, 48'd1, 1);
		write_reg(REG_PULSE_CYCLES, 48'd3, 32);
		write_reg(REG_CYCLES_PER_SECOND, 48'd40, 32);
		send_word(OP_INSERT, 32'd0, 3'd0, 8'd200, 8'd0);
		send_word(OP_TICK, 32'd4, 3'd0, 8'd0, 8'd0);
		send_word(OP_TICK, 32'd15, 3'd0, 8'd0, 8'd0);
		send_word(OP_TICK, 32'd1, 3'd0, 8'd0, 8'd0);
		send_word(OP_INSERT, 32'd0, 3'd5, 8'd11, 8'd0);

		// Channel style with inverted inhibit sense and the longest pulse.
		settle_idle();
		write_reg(REG_COMM_STYLE, 48'(STYLE_CHANNEL), 2);
		write_reg(REG_COMM_INVERT, 48'd0, 1);
		write_reg(REG_PULSE_CYCLES, 48'hFFFF_FFFF, 32);
		write_reg(REG_INHIBIT_INVERT, 48'h3F, 6);
		write_reg(REG_DRIVE_MAP, 48'h0_53C8, 18);
		send_word(OP_INSERT, 32'd0, 3'd4, 8'd0, 8'd0);
		send_word(OP_WRITE, 32'd0, 3'd0, 8'd0, 8'h00);
		send_word(OP_INSERT, 32'd0, 3'd4, 8'd0, 8'd0);
		send_word(OP_TICK, 32'hFFFFFFFF, 3'd0, 8'd0, 8'd0);
		send_word(OP_READ, 32'd0, 3'd0, 8'd0, 8'd0);

		for (int p = 0; p < 8; p++) begin
			settle_idle();
			configure_phase(p);
			no_idle = (p == 4);
			if (p == 2) begin
				hold_request = 1'b1;
			end
			repeat (144) random_word();
		end
		no_idle = 1'b0;

		settle_idle();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("coin_acceptor_interface verification clean");
		end else begin
			$display("coin_acceptor_interface verification failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("coin_acceptor_interface verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/cai_pkg.sv
rtl/cai_cfg_regs.sv
rtl/cai_core.sv
rtl/coin_acceptor_interface.sv
rtl/cai_checker.sv
tb/coin_acceptor_interface_checker.sv
tb/coin_acceptor_interface_tb.sv
